[src/sfpd_pkg.sv]
// ----------------------------------------------------------------------------
// sfpd_pkg
// Shared types and constants of the sync-framed packet deframer.
// ----------------------------------------------------------------------------
package sfpd_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hA5;
    localparam logic [7:0] SYNC_SECOND = 8'h5A;
    localparam logic [7:0] END_FIRST   = 8'hCC;
    localparam logic [7:0] END_SECOND  = 8'h33;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PAYLOAD  = 3'd1,
        EV_GOOD     = 3'd2,
        EV_SUMERR   = 3'd3,
        EV_BADSTART = 3'd4,
        EV_BADEND   = 3'd5
    } event_t;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_SUMHI = 3'd4,
        PH_SUMLO = 3'd5,
        PH_END1  = 3'd6,
        PH_END2  = 3'd7
    } phase_t;

    // result of one byte, as handed from the frame tracker to the output stage
    typedef struct packed {
        event_t      event_res;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  frame_length;
        logic [15:0] received_sum;
        logic [15:0] computed_sum;
    } result_t;

endpackage

[src/sfpd_if.sv]
// ----------------------------------------------------------------------------
// sfpd_if
// Valid/ready channels of the deframer: received bytes in, results out.
// ----------------------------------------------------------------------------
interface sfpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfpd_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  frame_length;
    logic [15:0] received_sum;
    logic [15:0] computed_sum;

    modport source (output valid, output event_res, output payload_byte,
                    output payload_index, output frame_length,
                    output received_sum, output computed_sum, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input payload_index, input frame_length,
                    input received_sum, input computed_sum, output ready);
endinterface

[src/sync_framed_packet_deframer.sv]
// ----------------------------------------------------------------------------
// sync_framed_packet_deframer
// Deframes A5 5A / length / payload / checksum / CC 33 frames from a byte
// stream, one result request for every received byte.
// ----------------------------------------------------------------------------
//  channel   dir  request fields
//  byte_ch   in   rx_byte
//  event_ch  out  event_res, payload_byte, payload_index, frame_length,
//                 received_sum, computed_sum
//
//  One byte per cycle while the output register is empty or event_ch.ready
//  is high; its result appears in the output register in the cycle after
//  it is taken, when the frame tracker updates. A pending result does not
//  block input while event_ch.ready is high. Reset puts the tracker in the
//  hunt for the first sync byte and empties the output register.
// ----------------------------------------------------------------------------
module sync_framed_packet_deframer
    import sfpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    sfpd_byte_if.sink          byte_ch,
    sfpd_event_if.source       event_ch
);

    result_t step_res;
    result_t res_reg;
    logic    out_valid_reg, out_valid_next;
    logic    take;

    assign byte_ch.ready  = !out_valid_reg || event_ch.ready;
    assign take           = byte_ch.valid && byte_ch.ready;
    assign out_valid_next = take || (out_valid_reg && !event_ch.ready);

    sfpd_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (byte_ch.rx_byte),
        .res     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= step_res;
    end

    assign event_ch.valid         = out_valid_reg;
    assign event_ch.event_res     = res_reg.event_res;
    assign event_ch.payload_byte  = res_reg.payload_byte;
    assign event_ch.payload_index = res_reg.payload_index;
    assign event_ch.frame_length  = res_reg.frame_length;
    assign event_ch.received_sum  = res_reg.received_sum;
    assign event_ch.computed_sum  = res_reg.computed_sum;

endmodule

[src/sfpd_tracker.sv]
// ----------------------------------------------------------------------------
// sfpd_tracker
// Frame state machine and checksum datapath; produces the result of the
// byte presented and updates its state when that byte is taken.
// ----------------------------------------------------------------------------
module sfpd_tracker
    import sfpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] rx_byte,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  taken_reg, taken_next;
    logic [15:0] sent_reg, sent_next;
    logic [7:0]  taken_inc;
    logic        finish;

    assign taken_inc = taken_reg + 8'd1;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT:  if (rx_byte == SYNC_FIRST) phase_next = PH_SYNC2;
            PH_SYNC2: phase_next = (rx_byte == SYNC_SECOND) ? PH_LEN : PH_HUNT;
            PH_LEN:   phase_next = (rx_byte == 8'd0) ? PH_SUMHI : PH_DATA;
            PH_DATA:  if (taken_inc >= len_reg) phase_next = PH_SUMHI;
            PH_SUMHI: phase_next = PH_SUMLO;
            PH_SUMLO: phase_next = PH_END1;
            PH_END1:  phase_next = (rx_byte == END_FIRST) ? PH_END2 : PH_HUNT;
            PH_END2:  phase_next = PH_HUNT;
            default:  phase_next = PH_HUNT;
        endcase
    end

    // result and datapath updates
    always_comb
    begin
        res            = '0;
        res.event_res  = EV_NONE;
        finish         = 1'b0;
        sum_next       = sum_reg;
        len_next       = len_reg;
        taken_next     = taken_reg;
        sent_next      = sent_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == SYNC_FIRST)
                    sum_next = '0;
                else
                    res.event_res = EV_BADSTART;
            end
            PH_SYNC2:
            begin
                if (rx_byte != SYNC_SECOND)
                begin
                    res.event_res = EV_BADSTART;
                    finish        = 1'b1;
                end
            end
            PH_LEN:
            begin
                len_next   = rx_byte;
                sum_next   = {8'd0, rx_byte};
                taken_next = '0;
            end
            PH_DATA:
            begin
                sum_next          = sum_reg + {8'd0, rx_byte};
                res.event_res     = EV_PAYLOAD;
                res.payload_byte  = rx_byte;
                res.payload_index = taken_reg;
                taken_next        = taken_inc;
            end
            PH_SUMHI: sent_next = {rx_byte, 8'd0};
            PH_SUMLO: sent_next = sent_reg + {8'd0, rx_byte};
            PH_END1:
            begin
                if (rx_byte != END_FIRST)
                begin
                    res.event_res = EV_BADEND;
                    finish        = 1'b1;
                end
            end
            PH_END2:
            begin
                if (rx_byte == END_SECOND)
                begin
                    res.event_res    = (sent_reg == sum_reg) ? EV_GOOD : EV_SUMERR;
                    res.received_sum = sent_reg;
                end
                else
                begin
                    res.event_res = EV_BADEND;
                end
                finish = 1'b1;
            end
            default: finish = 1'b1;
        endcase
        // result shows the frame just ended, state is then cleared
        res.frame_length = len_next;
        res.computed_sum = sum_next;
        if (finish)
        begin
            sum_next   = '0;
            len_next   = '0;
            taken_next = '0;
            sent_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            sum_reg   <= '0;
            len_reg   <= '0;
            taken_reg <= '0;
            sent_reg  <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            len_reg   <= len_next;
            taken_reg <= taken_next;
            sent_reg  <= sent_next;
        end
    end

endmodule

[src/sfpd_checker.sv]
// ----------------------------------------------------------------------------
// sfpd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sfpd_checker
    import sfpd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  event_res,
    input logic [7:0]  payload_byte,
    input logic [7:0]  payload_index,
    input logic [15:0] received_sum,
    input logic [15:0] computed_sum
);

    // stalled request holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res)
            && $stable(computed_sum))
        else $error("stalled result changed");

    // empty output register never blocks input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_PAYLOAD |-> payload_byte == 8'd0
            && payload_index == 8'd0)
        else $error("payload fields set outside payload event");

    a_rsum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && received_sum != 16'd0 |->
            event_res == EV_GOOD || event_res == EV_SUMERR)
        else $error("received sum shown outside frame end");

    a_good: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_GOOD |-> received_sum == computed_sum)
        else $error("frame good with mismatched sums");

endmodule

bind sync_framed_packet_deframer sfpd_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (byte_ch.ready),
    .out_valid     (event_ch.valid),
    .out_ready     (event_ch.ready),
    .event_res     (event_ch.event_res),
    .payload_byte  (event_ch.payload_byte),
    .payload_index (event_ch.payload_index),
    .received_sum  (event_ch.received_sum),
    .computed_sum  (event_ch.computed_sum)
);
